@@ src/gti_pkg.sv @@
// Shared types and constants for the grid tile index block.
package gti_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int NUM_DIMS   = 4;
    localparam int COORD_W    = 17;
    localparam int OFFSET_W   = 18;
    localparam int COUNT_W    = 8;
    localparam int INV_W      = 12;
    localparam int PART_W     = 19;
    localparam int POS_W      = 18;
    localparam int PROD1_W    = POS_W + COUNT_W;
    localparam int PROD2_W    = PROD1_W + INV_W;
    localparam int FRAC_SHIFT = 24;
    localparam int INDEX_W    = 32;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 4;
    localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

    localparam logic [INV_W-1:0] ONE_Q48 = 12'h100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS_IN_USE  = 3'd0,
        CFG_CELLS        = 3'd1,
        CFG_INV_SCALES   = 3'd2,
        CFG_PERIODIC     = 3'd3,
        CFG_OFFSET0      = 3'd4,
        CFG_OFFSET1      = 3'd5,
        CFG_OFFSET2      = 3'd6,
        CFG_OFFSET3      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                       active;
        logic                       periodic;
        logic [COUNT_W-1:0]         count;
        logic [INV_W-1:0]           inv;
        logic signed [OFFSET_W-1:0] offset;
    } lane_cfg_t;

endpackage

@@ src/grid_tile_index.sv @@
// Top level of the grid tile index block: configuration, lanes and flow control.
//
// Usage:
//   Input channel in_valid/in_ready carries one state vector (coord_dim0..3)
//   per transfer. Output channel out_valid/out_ready carries the tile index
//   and the four clamped cell numbers of that vector, in input order.
//   Configuration is a write port (cfg_write, cfg_index, cfg_data); write it
//   only while no transfer is in flight.
//   Throughput: one transfer per cycle while the receiver takes results,
//   set by the 8-stage pipeline (4 lane stages: offset and wrap, two
//   multiplies, clamp; 4 merge stages building the mixed-radix index).
//   Each stage holds its own valid bit and fills when it is empty or when
//   the next one is loading, so bubbles collapse and in_ready stays high
//   while any stage is free, even with a result waiting at the output.
//   When the receiver stalls with all 8 stages full, in_ready drops and
//   every stage holds.
//   Reset empties the pipeline and loads the register defaults: four
//   dimensions, one cell each, unit scales, no wrap, zero offsets.
module grid_tile_index
    import gti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_W-1:0]      coord_dim0,
    input  logic [COORD_W-1:0]      coord_dim1,
    input  logic [COORD_W-1:0]      coord_dim2,
    input  logic [COORD_W-1:0]      coord_dim3,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [INDEX_W-1:0]      tile_index,
    output logic [COUNT_W-1:0]      cell_dim0,
    output logic [COUNT_W-1:0]      cell_dim1,
    output logic [COUNT_W-1:0]      cell_dim2,
    output logic [COUNT_W-1:0]      cell_dim3
);

    logic [2:0]                     dims_reg;
    logic [31:0]                    cells_reg;
    logic [CFG_DATA_W-1:0]          inv_reg;
    logic [NUM_DIMS-1:0]            periodic_reg;
    logic [NUM_DIMS-1:0][OFFSET_W-1:0] offset_reg;

    logic [NUM_STAGES-1:0]          valid_reg, valid_next;
    logic [NUM_STAGES:0]            en;

    logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
    logic [NUM_DIMS-1:0][COUNT_W-1:0] count;
    logic [NUM_DIMS-1:0][COUNT_W-1:0] lane_cell;
    logic [NUM_DIMS-1:0][COUNT_W-1:0] out_cell;
    lane_cfg_t                        lane_cfg [NUM_DIMS];

    assign coord[0] = coord_dim0;
    assign coord[1] = coord_dim1;
    assign coord[2] = coord_dim2;
    assign coord[3] = coord_dim3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg     <= 3'd4;
            cells_reg    <= 32'h0101_0101;
            inv_reg      <= 48'h1001_0010_0100;
            periodic_reg <= '0;
            offset_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIMS_IN_USE: dims_reg     <= cfg_data[2:0];
                CFG_CELLS:       cells_reg    <= cfg_data[31:0];
                CFG_INV_SCALES:  inv_reg      <= cfg_data;
                CFG_PERIODIC:    periodic_reg <= cfg_data[NUM_DIMS-1:0];
                CFG_OFFSET0:     offset_reg[0] <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET1:     offset_reg[1] <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET2:     offset_reg[2] <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET3:     offset_reg[3] <= cfg_data[OFFSET_W-1:0];
                default:         ;
            endcase
        end
    end

    for (genvar d = 0; d < NUM_DIMS; d++)
    begin : g_lane
        assign count[d] = (cells_reg[8*d +: COUNT_W] == '0) ? COUNT_W'(1)
                                                            : cells_reg[8*d +: COUNT_W];
        assign lane_cfg[d].active   = (d < MAX_DIMS) && (dims_reg > 3'(d));
        assign lane_cfg[d].periodic = periodic_reg[d];
        assign lane_cfg[d].count    = count[d];
        assign lane_cfg[d].inv      = inv_reg[INV_W*d +: INV_W];
        assign lane_cfg[d].offset   = $signed(offset_reg[d]);

        gti_lane u_lane (
            .clk      (clk),
            .en       (en[LANE_STAGES-1:0]),
            .cfg      (lane_cfg[d]),
            .coord    (coord[d]),
            .cell_num (lane_cell[d])
        );
    end

    gti_merge u_merge (
        .clk        (clk),
        .en         (en[NUM_STAGES-1:LANE_STAGES]),
        .count      (count),
        .cell_in    (lane_cell),
        .cell_out   (out_cell),
        .tile_index (tile_index)
    );

    // stage k loads when empty or when stage k+1 is loading
    always_comb
    begin
        en[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign cell_dim0 = out_cell[0];
    assign cell_dim1 = out_cell[1];
    assign cell_dim2 = out_cell[2];
    assign cell_dim3 = out_cell[3];

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transfer not captured in first stage");

    a_full_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) == NUM_STAGES) && !out_ready |=> $stable(valid_reg))
        else $error("full pipeline moved during stall");

endmodule

@@ src/gti_lane.sv @@
// One dimension lane: offset, wrap, scale and clamp to a cell number.
module gti_lane
    import gti_pkg::*;
(
    input  logic                     clk,
    input  logic [LANE_STAGES-1:0]   en,
    input  lane_cfg_t                cfg,
    input  logic [COORD_W-1:0]       coord,
    output logic [COUNT_W-1:0]       cell_num
);

    logic signed [PART_W-1:0] part;
    logic signed [PART_W-1:0] part_w;
    logic                     pos;
    logic [POS_W-1:0]         pos_next, pos_reg;
    logic [PROD1_W-1:0]       prod1_next, prod1_reg;
    logic [PROD2_W-1:0]       prod2_next, prod2_reg;
    logic [PROD2_W-FRAC_SHIFT-1:0] quot;
    logic [COUNT_W-1:0]       cell_next, cell_reg;

    always_comb
    begin
        part = $signed({2'b00, coord}) - $signed({cfg.offset[OFFSET_W-1], cfg.offset});
        if (cfg.periodic && (cfg.inv <= ONE_Q48))
        begin
            part_w = $signed({3'b000, part[15:0]});
        end
        else
        begin
            part_w = part;
        end
        pos = !part_w[PART_W-1] && (part_w != '0);
        pos_next = (cfg.active && pos) ? part_w[POS_W-1:0] : '0;
    end

    assign prod1_next = pos_reg * cfg.count;
    assign prod2_next = prod1_reg * cfg.inv;
    assign quot = prod2_reg[PROD2_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (quot >= {{(PROD2_W-FRAC_SHIFT-COUNT_W){1'b0}}, cfg.count})
        begin
            cell_next = cfg.count - COUNT_W'(1);
        end
        else
        begin
            cell_next = quot[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) pos_reg   <= pos_next;
        if (en[1]) prod1_reg <= prod1_next;
        if (en[2]) prod2_reg <= prod2_next;
        if (en[3]) cell_reg  <= cell_next;
    end

    assign cell_num = cell_reg;

endmodule

@@ src/gti_merge.sv @@
// Merge stage: mixed-radix tile index from the lane cells.
module gti_merge
    import gti_pkg::*;
(
    input  logic                              clk,
    input  logic [MERGE_STAGES-1:0]           en,
    input  logic [NUM_DIMS-1:0][COUNT_W-1:0]  count,
    input  logic [NUM_DIMS-1:0][COUNT_W-1:0]  cell_in,
    output logic [NUM_DIMS-1:0][COUNT_W-1:0]  cell_out,
    output logic [INDEX_W-1:0]                tile_index
);

    logic [NUM_DIMS-1:0][COUNT_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg;
    logic [15:0] t1_next, t1_reg, p01_next, p01_reg;
    logic [23:0] t2_next, t2_reg, p012_next, p012_reg;
    logic [16:0] s1_next, s1_reg;
    logic [24:0] s2_next, s2_reg;
    logic [31:0] t3_next, t3_reg;
    logic [INDEX_W-1:0] idx_next, idx_reg;

    assign t1_next   = cell_in[1] * count[0];
    assign p01_next  = count[0] * count[1];
    assign t2_next   = c1_reg[2] * p01_reg;
    assign p012_next = p01_reg * count[2];
    assign s1_next   = {9'd0, c1_reg[0]} + {1'b0, t1_reg};
    assign t3_next   = c2_reg[3] * p012_reg;
    assign s2_next   = {8'd0, s1_reg} + {1'b0, t2_reg};
    assign idx_next  = INDEX_W'({7'd0, s2_reg}) + INDEX_W'(t3_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg  <= cell_in;
            t1_reg  <= t1_next;
            p01_reg <= p01_next;
        end
        if (en[1])
        begin
            c2_reg   <= c1_reg;
            t2_reg   <= t2_next;
            p012_reg <= p012_next;
            s1_reg   <= s1_next;
        end
        if (en[2])
        begin
            c3_reg <= c2_reg;
            t3_reg <= t3_next;
            s2_reg <= s2_next;
        end
        if (en[3])
        begin
            c4_reg  <= c3_reg;
            idx_reg <= idx_next;
        end
    end

    assign cell_out   = c4_reg;
    assign tile_index = idx_reg;

endmodule

@@ tb/tile_index_checker.sv @@
`timescale 1ns / 1ps
// Checker for grid_tile_index: mirrors the registers, predicts every tile and compares results.
module tile_index_checker
    import gti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COORD_W-1:0]    coord_dim0,
    input  logic [COORD_W-1:0]    coord_dim1,
    input  logic [COORD_W-1:0]    coord_dim2,
    input  logic [COORD_W-1:0]    coord_dim3,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [INDEX_W-1:0]    tile_index,
    input  logic [COUNT_W-1:0]    cell_dim0,
    input  logic [COUNT_W-1:0]    cell_dim1,
    input  logic [COUNT_W-1:0]    cell_dim2,
    input  logic [COUNT_W-1:0]    cell_dim3,
    output int                    mismatches,
    output int                    in_flight
);

    typedef struct packed {
        logic [INDEX_W-1:0]               tile_index;
        logic [NUM_DIMS-1:0][COUNT_W-1:0] cells;
    } tile_t;

    tile_t                          expected_tiles[$];
    logic [2:0]                     dims_cfg;
    logic [NUM_DIMS*COUNT_W-1:0]    counts_cfg;
    logic [NUM_DIMS*INV_W-1:0]      inv_cfg;
    logic [NUM_DIMS-1:0]            wrap_cfg;
    logic signed [OFFSET_W-1:0]     offset_cfg [NUM_DIMS];

    function automatic tile_t predict_tile(input logic [NUM_DIMS-1:0][COORD_W-1:0] coords);
        tile_t           res;
        longint          part;
        longint unsigned count;
        longint unsigned inv;
        longint unsigned cell_num;
        longint unsigned index;
        longint unsigned radix;
        int              used;
        res   = '0;
        index = 0;
        radix = 1;
        used  = dims_cfg;
        if (used > MAX_DIMS)
        begin
            used = MAX_DIMS;
        end
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if (d < used)
            begin
                count = counts_cfg[COUNT_W*d +: COUNT_W];
                if (count == 0)
                begin
                    count = 1;
                end
                inv  = inv_cfg[INV_W*d +: INV_W];
                part = longint'(coords[d]) - longint'(offset_cfg[d]);
                if (wrap_cfg[d] && inv <= ONE_Q48)
                begin
                    part = part & 64'hFFFF;
                end
                cell_num = 0;
                if (part > 0)
                begin
                    cell_num = (longint'(part) * count * inv) >> FRAC_SHIFT;
                    if (cell_num >= count)
                    begin
                        cell_num = count - 1;
                    end
                end
                index        += cell_num * radix;
                radix        *= count;
                res.cells[d]  = cell_num[COUNT_W-1:0];
            end
        end
        res.tile_index = index[INDEX_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] tile mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_t                            want;
        logic [NUM_DIMS-1:0][COUNT_W-1:0] got_cells;
        if (!rst_n)
        begin
            dims_cfg   = 3'd4;
            counts_cfg = 32'h0101_0101;
            inv_cfg    = 48'h100_100_100_100;
            wrap_cfg   = '0;
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                offset_cfg[d] = '0;
            end
            expected_tiles.delete();
            mismatches = 0;
            in_flight <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tiles.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, tile_index %0d", tile_index));
                end
                else
                begin
                    want      = expected_tiles.pop_front();
                    got_cells = {cell_dim3, cell_dim2, cell_dim1, cell_dim0};
                    if (tile_index !== want.tile_index)
                    begin
                        report_mismatch($sformatf("tile_index got %0d want %0d",
                                                  tile_index, want.tile_index));
                    end
                    for (int d = 0; d < NUM_DIMS; d++)
                    begin
                        if (got_cells[d] !== want.cells[d])
                        begin
                            report_mismatch($sformatf("cell_dim%0d got %0d want %0d",
                                                      d, got_cells[d], want.cells[d]));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_tiles.push_back(
                    predict_tile({coord_dim3, coord_dim2, coord_dim1, coord_dim0}));
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DIMS_IN_USE: dims_cfg      = cfg_data[2:0];
                    CFG_CELLS:       counts_cfg    = cfg_data[NUM_DIMS*COUNT_W-1:0];
                    CFG_INV_SCALES:  inv_cfg       = cfg_data[NUM_DIMS*INV_W-1:0];
                    CFG_PERIODIC:    wrap_cfg      = cfg_data[NUM_DIMS-1:0];
                    CFG_OFFSET0:     offset_cfg[0] = cfg_data[OFFSET_W-1:0];
                    CFG_OFFSET1:     offset_cfg[1] = cfg_data[OFFSET_W-1:0];
                    CFG_OFFSET2:     offset_cfg[2] = cfg_data[OFFSET_W-1:0];
                    CFG_OFFSET3:     offset_cfg[3] = cfg_data[OFFSET_W-1:0];
                    default:         ;
                endcase
            end
            in_flight <= expected_tiles.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the grid_tile_index testbench: clock, reset, register settings, stimulus and verdict.
module tb_top;
    import gti_pkg::*;

    localparam int RAND_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 148;
    localparam int CALM_PHASE      = 5;

    localparam logic [31:0]                      D2_CELLS = 32'h01_00_FF_08;
    localparam logic [47:0]                      D2_INVS  = 48'h101_100_0FF_FFF;
    localparam logic [3:0]                       D2_WRAP  = 4'b1011;
    localparam logic [NUM_DIMS-1:0][OFFSET_W-1:0] D2_OFFS =
        {18'h10000, 18'h30000, 18'h1FFFF, 18'h20000};

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [COORD_W-1:0]    coord_dim0 = '0;
    logic [COORD_W-1:0]    coord_dim1 = '0;
    logic [COORD_W-1:0]    coord_dim2 = '0;
    logic [COORD_W-1:0]    coord_dim3 = '0;
    logic                  out_ready  = 1'b0;
    logic                  steady     = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [INDEX_W-1:0]    tile_index;
    logic [COUNT_W-1:0]    cell_dim0;
    logic [COUNT_W-1:0]    cell_dim1;
    logic [COUNT_W-1:0]    cell_dim2;
    logic [COUNT_W-1:0]    cell_dim3;
    int                    mismatches;
    int                    in_flight;

    grid_tile_index u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coord_dim0 (coord_dim0),
        .coord_dim1 (coord_dim1),
        .coord_dim2 (coord_dim2),
        .coord_dim3 (coord_dim3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tile_index (tile_index),
        .cell_dim0  (cell_dim0),
        .cell_dim1  (cell_dim1),
        .cell_dim2  (cell_dim2),
        .cell_dim3  (cell_dim3)
    );

    tile_index_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coord_dim0 (coord_dim0),
        .coord_dim1 (coord_dim1),
        .coord_dim2 (coord_dim2),
        .coord_dim3 (coord_dim3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tile_index (tile_index),
        .cell_dim0  (cell_dim0),
        .cell_dim1  (cell_dim1),
        .cell_dim2  (cell_dim2),
        .cell_dim3  (cell_dim3),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 7);
    end

    initial
    begin
        #400_000;
        $display("tb_top failed");
        $finish;
    end

    // fill the bits above the register width with junk; the block must drop them
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] junk = {$urandom, $urandom};
        logic [CFG_DATA_W-1:0] keep = (48'd1 << width) - 48'd1;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (junk & ~keep) | (value & keep);
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] dims, input logic [31:0] counts,
                             input logic [47:0] invs, input logic [3:0] wrap,
                             input logic [NUM_DIMS-1:0][OFFSET_W-1:0] offs);
        write_reg(CFG_DIMS_IN_USE, dims, 3);
        write_reg(CFG_CELLS, counts, 32);
        write_reg(CFG_INV_SCALES, invs, 48);
        write_reg(CFG_PERIODIC, wrap, 4);
        write_reg(CFG_OFFSET0, offs[0], OFFSET_W);
        write_reg(CFG_OFFSET1, offs[1], OFFSET_W);
        write_reg(CFG_OFFSET2, offs[2], OFFSET_W);
        write_reg(CFG_OFFSET3, offs[3], OFFSET_W);
        cfg_write <= 1'b0;
    endtask

    task automatic send_state(input logic [NUM_DIMS-1:0][COORD_W-1:0] vec);
        while (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        coord_dim0 <= vec[0];
        coord_dim1 <= vec[1];
        coord_dim2 <= vec[2];
        coord_dim3 <= vec[3];
        do @(posedge clk); while (!in_ready);
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
        begin
            @(posedge clk);
        end
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return 17'd65536;
            2:       return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        unique case ($urandom_range(7))
            0:       return 18'h30000;
            1:       return 18'h10000;
            2:       return OFFSET_W'($urandom);
            3:       return '0;
            default: return OFFSET_W'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic logic [INV_W-1:0] rand_inv();
        unique case ($urandom_range(7))
            0:       return ONE_Q48;
            1:       return '0;
            2:       return 12'hFFF;
            3:       return INV_W'($urandom_range(0, 256));
            4:       return INV_W'($urandom);
            default: return INV_W'($urandom_range(0, 512));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return 8'hFF;
            2:       return 8'd1;
            3:       return COUNT_W'($urandom);
            default: return COUNT_W'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [2:0] rand_dims();
        unique case ($urandom_range(9))
            0:       return 3'd0;
            1:       return 3'($urandom_range(5, 7));
            default: return 3'($urandom_range(1, 4));
        endcase
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_state({4{17'd0}});
        send_state({4{17'h1FFFF}});
        settle();

        configure(3'd4, 32'hFF_10_03_00, 48'hFFF_100_000_080, 4'b0110,
                  {18'h3FFFF, 18'h10000, 18'h30000, 18'h00000});
        send_state({4{17'd0}});
        send_state({4{17'd65536}});
        send_state({4{17'h1FFFF}});
        send_state({17'h00001, 17'h12345, 17'h04000, 17'h08000});
        send_state({17'h10000, 17'h0FFFF, 17'h00001, 17'h00001});
        send_state({17'h0AAAA, 17'h1FFFF, 17'h00000, 17'h10000});
        settle();

        configure(3'd7, D2_CELLS, D2_INVS, D2_WRAP, D2_OFFS);
        send_state({4{17'd0}});
        send_state({4{17'd65536}});
        send_state({4{17'h1FFFF}});
        send_state({17'h0FFFF, 17'h10001, 17'h0AAAA, 17'h15555});
        send_state({17'h18000, 17'h08000, 17'h1FFFE, 17'h00001});
        settle();

        configure(3'd0, D2_CELLS, D2_INVS, D2_WRAP, D2_OFFS);
        send_state({4{17'h1FFFF}});
        send_state({17'h0FFFF, 17'h10001, 17'h0AAAA, 17'h15555});
        settle();

        for (int dims = 1; dims <= 3; dims++)
        begin
            configure(3'(dims), D2_CELLS, D2_INVS, D2_WRAP, D2_OFFS);
            send_state({4{17'd65536}});
            send_state({17'h18000, 17'h08000, 17'h1FFFE, 17'h00001});
            settle();
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            steady <= (phase == CALM_PHASE);
            configure(rand_dims(),
                      {rand_count(), rand_count(), rand_count(), rand_count()},
                      {rand_inv(), rand_inv(), rand_inv(), rand_inv()},
                      4'($urandom_range(0, 15)),
                      {rand_offset(), rand_offset(), rand_offset(), rand_offset()});
            repeat (ITEMS_PER_PHASE)
            begin
                send_state({rand_coord(), rand_coord(), rand_coord(), rand_coord()});
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
